// ===== hw/rtl/dlt_pkg.sv =====
// shared types, codes and character helpers for the dfa lexical tokenizer
package dlt_pkg;

  localparam int unsigned LENGTH_WIDTH_DEFAULT = 8;

  localparam logic [7:0] CHAR_END = "$";
  localparam logic [7:0] CHAR_DOT = ".";

  localparam logic [47:0] KW_IF     = 48'("if");
  localparam logic [47:0] KW_WHILE  = 48'("while");
  localparam logic [47:0] KW_RETURN = 48'("return");
  localparam logic [47:0] KW_ELSE   = 48'("else");
  localparam logic [47:0] KW_INT    = 48'("int");
  localparam logic [47:0] KW_FLOAT  = 48'("float");

  typedef enum logic [4:0] {
    KIND_IDENT  = 5'd0,
    KIND_INT    = 5'd1,
    KIND_REAL   = 5'd2,
    KIND_STRING = 5'd3,
    KIND_TYPE   = 5'd4,
    KIND_ADD    = 5'd5,
    KIND_MUL    = 5'd6,
    KIND_REL    = 5'd7,
    KIND_OR     = 5'd8,
    KIND_AND    = 5'd9,
    KIND_NOT    = 5'd10,
    KIND_EQUAL  = 5'd11,
    KIND_SEMI   = 5'd12,
    KIND_COMMA  = 5'd13,
    KIND_LPAREN = 5'd14,
    KIND_RPAREN = 5'd15,
    KIND_LBRACE = 5'd16,
    KIND_RBRACE = 5'd17,
    KIND_ASSIGN = 5'd18,
    KIND_IF     = 5'd19,
    KIND_WHILE  = 5'd20,
    KIND_RETURN = 5'd21,
    KIND_ELSE   = 5'd22,
    KIND_END    = 5'd23,
    KIND_ERROR  = 5'd24
  } token_kind_e;

  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_IDENT = 4'd1,
    ST_INT   = 4'd2,
    ST_DOT   = 4'd3,
    ST_REAL  = 4'd4,
    ST_EQ    = 4'd5,
    ST_BANG  = 4'd6,
    ST_REL   = 4'd7,
    ST_AMP   = 4'd8,
    ST_BAR   = 4'd9
  } scan_state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] token_length;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] count;
    out_beat_t  tok0;
    out_beat_t  tok1;
  } scan_res_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c inside {8'h20, 8'h09, 8'h0A, 8'h0D});
  endfunction

endpackage

// ===== hw/rtl/dlt_scanner.sv =====
// scanner state registers and per-byte transition with token classification
module dlt_scanner import dlt_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      acc_i,
  input  in_beat_t  beat_i,
  output scan_res_t res_o
);

  localparam int unsigned WideW = LENGTH_WIDTH + 8;

  scan_state_e             st_q, st_d;
  logic [47:0]             pre_q, pre_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic                    tl_q, tl_d;

  logic [LENGTH_WIDTH-1:0] len_inc;
  logic                    tl_add;
  logic [7:0]              c;
  logic                    is_end;

  function automatic logic [7:0] len_report(logic [LENGTH_WIDTH-1:0] len);
    logic [WideW-1:0] wide;
    wide = WideW'(len);
    return (wide > WideW'(255)) ? 8'hFF : wide[7:0];
  endfunction

  function automatic logic [4:0] ident_kind(logic [LENGTH_WIDTH-1:0] len,
                                            logic [47:0] pre, logic tl);
    logic [4:0] k;
    k = KIND_IDENT;
    if (!tl) begin
      if (len == LENGTH_WIDTH'(2) && pre == KW_IF) k = KIND_IF;
      else if (len == LENGTH_WIDTH'(5) && pre == KW_WHILE) k = KIND_WHILE;
      else if (len == LENGTH_WIDTH'(6) && pre == KW_RETURN) k = KIND_RETURN;
      else if (len == LENGTH_WIDTH'(4) && pre == KW_ELSE) k = KIND_ELSE;
      else if (len == LENGTH_WIDTH'(3) && pre == KW_INT) k = KIND_TYPE;
      else if (len == LENGTH_WIDTH'(5) && pre == KW_FLOAT) k = KIND_TYPE;
    end
    return k;
  endfunction

  assign is_end  = beat_i.end_of_input;
  assign c       = is_end ? CHAR_END : beat_i.char_code;
  assign len_inc = (len_q == '1) ? len_q : len_q + LENGTH_WIDTH'(1);
  assign tl_add  = tl_q | (len_q >= LENGTH_WIDTH'(6));

  always_comb begin
    logic       again;
    logic       a_v, b_v;
    logic [4:0] a_kind, b_kind;
    logic [7:0] a_len, b_len;
    logic       do_add, do_begin;

    st_d     = st_q;
    pre_d    = pre_q;
    len_d    = len_q;
    tl_d     = tl_q;
    again    = 1'b1;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_kind   = KIND_ERROR;
    b_kind   = KIND_ERROR;
    a_len    = 8'd1;
    b_len    = 8'd1;
    do_add   = 1'b0;
    do_begin = 1'b0;

    case (st_q)
      ST_IDENT: begin
        if (!is_end && (is_letter(c) || is_digit(c))) begin
          do_add = 1'b1;
          again  = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = ident_kind(len_q, pre_q, tl_q);
          a_len  = len_report(len_q);
        end
      end
      ST_INT: begin
        if (!is_end && is_digit(c)) begin
          do_add = 1'b1;
          again  = 1'b0;
        end else if (!is_end && c == CHAR_DOT) begin
          do_add = 1'b1;
          st_d   = ST_DOT;
          again  = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = KIND_INT;
          a_len  = len_report(len_q);
        end
      end
      ST_DOT: begin
        if (!is_end && is_digit(c)) begin
          do_add = 1'b1;
          st_d   = ST_REAL;
          again  = 1'b0;
        end else if (is_end) begin
          a_v    = 1'b1;
          a_kind = KIND_ERROR;
          a_len  = len_report(len_q);
        end else begin
          // bad byte after the dot is swallowed into the error token
          do_add = 1'b1;
          a_v    = 1'b1;
          a_kind = KIND_ERROR;
          a_len  = len_report(len_inc);
          st_d   = ST_START;
          again  = 1'b0;
        end
      end
      ST_REAL: begin
        if (!is_end && is_digit(c)) begin
          do_add = 1'b1;
          again  = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = KIND_REAL;
          a_len  = len_report(len_q);
        end
      end
      ST_EQ, ST_BANG, ST_REL: begin
        a_v = 1'b1;
        if (c == "=") begin
          a_kind = (st_q == ST_REL) ? KIND_REL : KIND_EQUAL;
          a_len  = 8'd2;
          st_d   = ST_START;
          again  = 1'b0;
        end else begin
          a_len = 8'd1;
          if (st_q == ST_EQ) a_kind = KIND_ASSIGN;
          else if (st_q == ST_BANG) a_kind = KIND_NOT;
          else a_kind = KIND_REL;
        end
      end
      ST_AMP, ST_BAR: begin
        a_v = 1'b1;
        if ((st_q == ST_AMP && c == "&") || (st_q == ST_BAR && c == "|")) begin
          a_kind = (st_q == ST_AMP) ? KIND_AND : KIND_OR;
          a_len  = 8'd2;
          st_d   = ST_START;
          again  = 1'b0;
        end else begin
          a_kind = KIND_ERROR;
          a_len  = 8'd1;
        end
      end
      default: ;
    endcase

    if (again) begin
      st_d = ST_START;
      if (is_end) begin
        b_v    = 1'b1;
        b_kind = KIND_END;
        b_len  = 8'd0;
      end else if (is_space(c)) begin
        b_v = 1'b0;
      end else if (is_letter(c)) begin
        do_begin = 1'b1;
        st_d     = ST_IDENT;
      end else if (is_digit(c)) begin
        do_begin = 1'b1;
        st_d     = ST_INT;
      end else begin
        b_v   = 1'b1;
        b_len = 8'd1;
        case (c)
          "+", "-": b_kind = KIND_ADD;
          "*", "/": b_kind = KIND_MUL;
          ";":      b_kind = KIND_SEMI;
          ",":      b_kind = KIND_COMMA;
          "(":      b_kind = KIND_LPAREN;
          ")":      b_kind = KIND_RPAREN;
          "{":      b_kind = KIND_LBRACE;
          "}":      b_kind = KIND_RBRACE;
          "$":      b_kind = KIND_END;
          "=": begin
            b_v  = 1'b0;
            st_d = ST_EQ;
          end
          "!": begin
            b_v  = 1'b0;
            st_d = ST_BANG;
          end
          "<", ">": begin
            b_v  = 1'b0;
            st_d = ST_REL;
          end
          "&": begin
            b_v  = 1'b0;
            st_d = ST_AMP;
          end
          "|": begin
            b_v  = 1'b0;
            st_d = ST_BAR;
          end
          default: b_kind = KIND_ERROR;
        endcase
      end
    end

    if (do_begin) begin
      len_d = LENGTH_WIDTH'(1);
      pre_d = {40'd0, c};
      tl_d  = 1'b0;
    end else if (do_add) begin
      len_d = len_inc;
      pre_d = {pre_q[39:0], c};
      tl_d  = tl_add;
    end

    res_o.count = {1'b0, a_v} + {1'b0, b_v};
    if (a_v) begin
      res_o.tok0 = '{token_kind: a_kind, token_length: a_len, last: !b_v};
    end else begin
      res_o.tok0 = '{token_kind: b_kind, token_length: b_len, last: 1'b1};
    end
    res_o.tok1 = '{token_kind: b_kind, token_length: b_len, last: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_START;
      pre_q <= '0;
      len_q <= '0;
      tl_q  <= 1'b0;
    end else if (acc_i) begin
      st_q  <= st_d;
      pre_q <= pre_d;
      len_q <= len_d;
      tl_q  <= tl_d;
    end
  end

endmodule

// ===== hw/rtl/dfa_lexical_tokenizer.sv =====
// the first token beat of a byte shows in the cycle after the byte beat is accepted
// throughput: one byte beat per cycle while each byte gives at most one token
// and the sink does not stall; a byte giving two tokens holds input until the
// two-entry result buffer drains, as it must before the next byte is taken
// reset: scanner returns to its start state and the result buffer empties
module dfa_lexical_tokenizer import dlt_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  scan_res_t  res;
  logic [1:0] cnt_q, cnt_d;
  out_beat_t  slot0_q, slot0_d;
  out_beat_t  slot1_q, slot1_d;
  logic       pop;
  logic       acc;
  logic [1:0] cnt_left;

  assign pop        = (cnt_q != 2'd0) && !out_stall_i;
  assign cnt_left   = cnt_q - {1'b0, pop};
  assign in_stall_o = (cnt_left != 2'd0);
  assign acc        = in_valid_i && !in_stall_o;

  dlt_scanner #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_scanner (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (acc),
    .beat_i(in_data_i),
    .res_o (res)
  );

  always_comb begin
    cnt_d   = cnt_left;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (acc) begin
      cnt_d   = res.count;
      slot0_d = res.tok0;
      slot1_d = res.tok1;
    end else if (pop) begin
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;

endmodule
